// ===== hw/rtl/fuf_pkg.sv =====
// Shared types and constants for the H.264 FU-A fragmenter.
package fuf_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAGMENT_SIZE  = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMESTAMP_STEP = 8'd1;

    localparam logic [11:0] FRAGMENT_SIZE_RESET  = 12'd1300;
    localparam logic [31:0] TIMESTAMP_STEP_RESET = 32'd3600;

    localparam logic [7:0] FU_A_TYPE  = 8'h1C;
    localparam logic [7:0] TYPE_MASK  = 8'h1F;
    localparam logic [7:0] NRI_F_MASK = 8'hE0;
    localparam logic [7:0] FU_START   = 8'h80;
    localparam logic [7:0] FU_END     = 8'h40;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    // One queued job: optional two header beats, then one data beat.
    typedef struct packed {
        logic       has_hdr;
        logic [7:0] ind_byte;
        logic [7:0] fu_byte;
        logic [7:0] data_byte;
        logic       pkt_end;
        logic       unit_last;
    } fuf_entry_t;

    typedef struct packed {
        logic       push;
        fuf_entry_t entry;
    } fuf_push_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        fuf_entry_t head;
    } fuf_status_t;

endpackage

// ===== hw/rtl/h264_nalu_fua_fragmenter.sv =====
// H.264 NAL unit to RTP single-NAL / FU-A packet fragmenter, top level.
// An input beat is written into the job queue, then loaded into the output register.
// Throughput: one input beat per cycle; an FU-A packet start adds two header beats,
// output runs at one beat per cycle while out_stall is low, a four-entry job queue
// absorbs the bursts and the input stalls while it is full.
// Reset (rst_n, async low) clears unit state, queue and output; fragment_size
// returns to 1300 and timestamp_step to 3600.
module h264_nalu_fua_fragmenter
    import fuf_pkg::*;
#(
    parameter int LENGTH_WIDTH = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 nalu_byte,
    input  logic                       unit_start,
    input  logic [LENGTH_WIDTH-1:0]    unit_length,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic                       packet_end,
    output logic [31:0]                timestamp_add,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0]                cfg_data
);

    logic [11:0] fragment_size_reg;
    logic [31:0] timestamp_step_reg;
    fuf_push_t   push;
    fuf_status_t status;
    logic        pop;
    logic        in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = status.full;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fragment_size_reg  <= FRAGMENT_SIZE_RESET;
            timestamp_step_reg <= TIMESTAMP_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FRAGMENT_SIZE)
            begin
                fragment_size_reg <= cfg_data[11:0];
            end
            else if (cfg_index == REG_TIMESTAMP_STEP)
            begin
                timestamp_step_reg <= cfg_data;
            end
        end
    end

    fuf_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .nalu_byte     (nalu_byte),
        .unit_start    (unit_start),
        .unit_length   (unit_length),
        .fragment_size (fragment_size_reg),
        .push_out      (push)
    );

    fuf_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .status  (status)
    );

    fuf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .status         (status),
        .timestamp_step (timestamp_step_reg),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .packet_end     (packet_end),
        .timestamp_add  (timestamp_add)
    );

endmodule

// ===== hw/rtl/fuf_front.sv =====
// Front end: accepts NAL unit bytes and classifies them into output jobs.
module fuf_front
    import fuf_pkg::*;
#(
    parameter int LENGTH_WIDTH = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              nalu_byte,
    input  logic                    unit_start,
    input  logic [LENGTH_WIDTH-1:0] unit_length,
    input  logic [11:0]             fragment_size,
    output fuf_push_t               push_out
);

    logic [LENGTH_WIDTH-1:0] bytes_left_reg, bytes_left_next;
    logic [11:0]             fill_count_reg, fill_count_next;
    logic [7:0]              indicator_reg, indicator_next;
    logic [4:0]              unit_type_reg, unit_type_next;
    logic                    fragmenting_reg, fragmenting_next;
    logic                    first_pending_reg, first_pending_next;

    logic [11:0]             fs;
    logic [LENGTH_WIDTH-1:0] fs_ext;
    logic [LENGTH_WIDTH-1:0] len;
    logic [LENGTH_WIDTH-1:0] len_m1;
    logic [LENGTH_WIDTH-1:0] bl_dec;
    logic [11:0]             fill_inc;
    logic [7:0]              fu_byte;

    always_comb
    begin
        fs       = (fragment_size == 12'd0) ? 12'd1 : fragment_size;
        fs_ext   = LENGTH_WIDTH'(fs);
        len      = (unit_length == '0) ? LENGTH_WIDTH'(1) : unit_length;
        len_m1   = len - LENGTH_WIDTH'(1);
        bl_dec   = bytes_left_reg - LENGTH_WIDTH'(1);
        fill_inc = fill_count_reg + 12'd1;
        fu_byte  = {3'b000, unit_type_reg};
        if (first_pending_reg)
        begin
            fu_byte = fu_byte | FU_START;
        end
        if (bytes_left_reg <= fs_ext)
        begin
            fu_byte = fu_byte | FU_END;
        end
    end

    always_comb
    begin
        bytes_left_next    = bytes_left_reg;
        fill_count_next    = fill_count_reg;
        indicator_next     = indicator_reg;
        unit_type_next     = unit_type_reg;
        fragmenting_next   = fragmenting_reg;
        first_pending_next = first_pending_reg;

        push_out.push               = 1'b0;
        push_out.entry.has_hdr      = 1'b0;
        push_out.entry.ind_byte     = indicator_reg;
        push_out.entry.fu_byte      = fu_byte;
        push_out.entry.data_byte    = nalu_byte;
        push_out.entry.pkt_end      = 1'b0;
        push_out.entry.unit_last    = 1'b0;

        if (accept)
        begin
            if (unit_start)
            begin
                bytes_left_next = len_m1;
                fill_count_next = 12'd0;
                if (len_m1 <= fs_ext)
                begin
                    fragmenting_next         = 1'b0;
                    first_pending_next       = 1'b0;
                    push_out.push            = 1'b1;
                    push_out.entry.pkt_end   = (len_m1 == '0);
                    push_out.entry.unit_last = (len_m1 == '0);
                end
                else
                begin
                    fragmenting_next   = 1'b1;
                    first_pending_next = 1'b1;
                    indicator_next     = (nalu_byte & NRI_F_MASK) | FU_A_TYPE;
                    unit_type_next     = nalu_byte[4:0] & TYPE_MASK[4:0];
                end
            end
            else if (bytes_left_reg != '0)
            begin
                bytes_left_next          = bl_dec;
                push_out.push            = 1'b1;
                if (!fragmenting_reg)
                begin
                    push_out.entry.pkt_end   = (bl_dec == '0);
                    push_out.entry.unit_last = (bl_dec == '0);
                end
                else
                begin
                    push_out.entry.has_hdr = (fill_count_reg == 12'd0);
                    if (fill_count_reg == 12'd0)
                    begin
                        first_pending_next = 1'b0;
                    end
                    fill_count_next = fill_inc;
                    if (bl_dec == '0)
                    begin
                        push_out.entry.pkt_end   = 1'b1;
                        push_out.entry.unit_last = 1'b1;
                        fill_count_next          = 12'd0;
                        fragmenting_next         = 1'b0;
                    end
                    else if (fill_inc >= fs)
                    begin
                        push_out.entry.pkt_end = 1'b1;
                        fill_count_next        = 12'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= '0;
            fill_count_reg    <= '0;
            indicator_reg     <= '0;
            unit_type_reg     <= '0;
            fragmenting_reg   <= 1'b0;
            first_pending_reg <= 1'b0;
        end
        else
        begin
            bytes_left_reg    <= bytes_left_next;
            fill_count_reg    <= fill_count_next;
            indicator_reg     <= indicator_next;
            unit_type_reg     <= unit_type_next;
            fragmenting_reg   <= fragmenting_next;
            first_pending_reg <= first_pending_next;
        end
    end

    fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !fragmenting_reg |-> (fill_count_reg == 12'd0))
        else $error("fill count nonzero outside fragmentation");

endmodule

// ===== hw/rtl/fuf_fifo.sv =====
// Short register queue of jobs between front end and back end.
module fuf_fifo
    import fuf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fuf_push_t   push_in,
    input  logic        pop,
    output fuf_status_t status
);

    fuf_entry_t                slots_reg [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_WIDTH-1:0] count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    always_comb
    begin
        status.full  = (count_reg == FIFO_CNT_WIDTH'(FIFO_DEPTH));
        status.empty = (count_reg == '0);
        status.head  = slots_reg[rd_ptr_reg];
        do_push      = push_in.push && !status.full;
        do_pop       = pop && !status.empty;
        wr_ptr_next  = do_push ? wr_ptr_reg + FIFO_PTR_WIDTH'(1) : wr_ptr_reg;
        rd_ptr_next  = do_pop ? rd_ptr_reg + FIFO_PTR_WIDTH'(1) : rd_ptr_reg;
        count_next   = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FIFO_CNT_WIDTH'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FIFO_CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_in.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_WIDTH'(FIFO_DEPTH))
        else $error("queue count out of range");

    no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_in.push |-> !status.full)
        else $error("push into full queue");

    no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/fuf_back.sv =====
// Back end: expands queued jobs into output beats behind an output register.
module fuf_back
    import fuf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fuf_status_t status,
    input  logic [31:0] timestamp_step,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        packet_end,
    output logic [31:0] timestamp_add
);

    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_FU    = 3'b010,
        PH_DATA  = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    logic [31:0] ts_reg, ts_next;
    logic        load;
    logic        data_beat;

    always_comb
    begin
        load       = (!valid_reg || !out_stall) && !status.empty;
        phase_next = phase_reg;
        data_beat  = 1'b0;
        byte_next  = status.head.data_byte;
        case (phase_reg)
            PH_FIRST:
            begin
                if (status.head.has_hdr)
                begin
                    byte_next  = status.head.ind_byte;
                    phase_next = load ? PH_FU : PH_FIRST;
                end
                else
                begin
                    data_beat = 1'b1;
                end
            end
            PH_FU:
            begin
                byte_next  = status.head.fu_byte;
                phase_next = load ? PH_DATA : PH_FU;
            end
            PH_DATA:
            begin
                data_beat  = 1'b1;
                phase_next = load ? PH_FIRST : PH_DATA;
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
        pop        = load && data_beat;
        end_next   = data_beat && status.head.pkt_end;
        ts_next    = (data_beat && status.head.unit_last) ? timestamp_step : 32'd0;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            end_reg  <= end_next;
            ts_reg   <= ts_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign packet_end    = end_reg;
    assign timestamp_add = ts_reg;

    hdr_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_FIRST) |-> (!status.empty && status.head.has_hdr))
        else $error("header phase without a header job");

    ts_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !packet_end) |-> (timestamp_add == 32'd0))
        else $error("timestamp step off a packet end");

endmodule
